// ===== hdl/crfd_pkg.sv =====
// Package with shared constants, codes and the job type of the frame rescaler.
`timescale 1ns / 1ps
`default_nettype none
package crfd_pkg;

  localparam int unsigned FRAME_DEPTH = 65536;
  localparam int unsigned ADDR_W = $clog2(FRAME_DEPTH);
  localparam int unsigned SAMP_W = 16;
  localparam logic [SAMP_W:0] DEPTH_LIMIT = (SAMP_W + 1)'(FRAME_DEPTH);

  localparam logic [5:0] BLANK_ROW = 6'd60;
  localparam logic [7:0] BLANK_PIXEL = 8'hFF;
  localparam logic [7:0] ZERO_PIXEL = 8'h00;
  localparam logic [SAMP_W-1:0] STRIDE_SMALL = 16'd80;
  localparam logic [SAMP_W-1:0] STRIDE_DIRECT = 16'd320;
  localparam logic [SAMP_W-1:0] STRIDE_LARGE = 16'd720;
  localparam logic [7:0] COL_GROUP = 8'd5;

  localparam int unsigned JQ_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] MODE_SMALL = 2'd0;
  localparam logic [1:0] MODE_DIRECT = 2'd1;
  localparam logic [1:0] MODE_LARGE = 2'd2;
  localparam logic [1:0] MODE_RESET = MODE_DIRECT;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_BLANK = 2'd2,
    OP_ZERO  = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SAMP_W-1:0] addr;
    logic [7:0]        data;
  } job_t;

endpackage
`default_nettype wire

// ===== hdl/camera_frame_rescale_for_display.sv =====
// Read words pass the job queue, the memory read register and the result queue.
// Throughput: one word per cycle (single frame memory port) while results drain.
// Writes produce no result and use the frame memory port.
// Reset clears the queues and sets the scale mode to the 120x160 source.
// The frame memory is not cleared; entries hold unknown data until written.
`timescale 1ns / 1ps
`default_nettype none
module camera_frame_rescale_for_display (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_command,
  input  wire logic [15:0] in_source_address,
  input  wire logic [7:0]  in_pixel_in,
  input  wire logic [5:0]  in_display_row,
  input  wire logic [6:0]  in_display_col,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_pixel_out,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_scale_mode
);

  logic accept;
  logic job_push;
  crfd_pkg::job_t front_job;
  logic q_valid;
  logic q_pop;
  crfd_pkg::job_t q_head;

  assign accept = in_push && !in_full;

  crfd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_scale_mode(cfg_scale_mode),
    .accept        (accept),
    .command       (in_command),
    .source_address(in_source_address),
    .pixel_in      (in_pixel_in),
    .display_row   (in_display_row),
    .display_col   (in_display_col),
    .job_push      (job_push),
    .job           (front_job)
  );

  crfd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .push_job(front_job),
    .full    (in_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  crfd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (q_valid),
    .job          (q_head),
    .job_pop      (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_pixel_out(out_pixel_out)
  );

endmodule
`default_nettype wire

// ===== hdl/crfd_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module crfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== hdl/crfd_front.sv =====
// Front end: mode register, command decode and source address computation.
`timescale 1ns / 1ps
`default_nettype none
module crfd_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_scale_mode,
  input  wire logic                 accept,
  input  wire logic                 command,
  input  wire logic [15:0]          source_address,
  input  wire logic [7:0]           pixel_in,
  input  wire logic [5:0]           display_row,
  input  wire logic [6:0]           display_col,
  output logic                      job_push,
  output crfd_pkg::job_t            job
);

  logic [1:0] mode_r;
  logic [1:0] mode_nxt;
  logic [7:0] col_j;
  logic [crfd_pkg::SAMP_W-1:0] row_w;
  logic [crfd_pkg::SAMP_W-1:0] samp_addr;
  logic write_in_range;

  always_comb begin
    mode_nxt = cfg_we ? cfg_scale_mode : mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= crfd_pkg::MODE_RESET;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // Every fifth intermediate column is skipped.
  assign col_j = ({3'b0, display_col[6:2]} * crfd_pkg::COL_GROUP) + {6'b0, display_col[1:0]};
  assign row_w = {10'b0, display_row};

  always_comb begin
    unique case (mode_r)
      crfd_pkg::MODE_SMALL: begin
        samp_addr = (row_w * crfd_pkg::STRIDE_SMALL) + {9'b0, col_j[7:1]};
      end
      crfd_pkg::MODE_DIRECT: begin
        samp_addr = (row_w * crfd_pkg::STRIDE_DIRECT) + {8'b0, col_j};
      end
      crfd_pkg::MODE_LARGE: begin
        samp_addr = (row_w * crfd_pkg::STRIDE_LARGE) + ({9'b0, col_j[7:1]} * 16'd3);
      end
      default: begin
        samp_addr = '0;
      end
    endcase
  end

  assign write_in_range = {1'b0, source_address} < crfd_pkg::DEPTH_LIMIT;

  always_comb begin
    job.data = pixel_in;
    job.addr = samp_addr;
    job.op = crfd_pkg::OP_READ;
    if (command == crfd_pkg::CMD_WRITE) begin
      job.op = crfd_pkg::OP_WRITE;
      job.addr = source_address;
    end else if (display_row >= crfd_pkg::BLANK_ROW) begin
      job.op = crfd_pkg::OP_BLANK;
    end else if (mode_r != crfd_pkg::MODE_SMALL && mode_r != crfd_pkg::MODE_DIRECT &&
                 mode_r != crfd_pkg::MODE_LARGE) begin
      job.op = crfd_pkg::OP_ZERO;
    end else if ({1'b0, samp_addr} >= crfd_pkg::DEPTH_LIMIT) begin
      job.op = crfd_pkg::OP_ZERO;
    end
  end

  // A write beyond the store is accepted and dropped.
  assign job_push = accept && !(command == crfd_pkg::CMD_WRITE && !write_in_range);

endmodule
`default_nettype wire

// ===== hdl/crfd_queue.sv =====
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module crfd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire crfd_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output crfd_pkg::job_t      head
);

  localparam int unsigned PTR_W = $clog2(crfd_pkg::JQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(crfd_pkg::JQ_DEPTH + 1);

  crfd_pkg::job_t slot_r [crfd_pkg::JQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic do_push;
  logic do_pop;

  assign full = cnt_r == CNT_W'(crfd_pkg::JQ_DEPTH);
  assign valid = cnt_r != '0;
  assign head = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/crfd_back.sv =====
// Back end: frame memory access, result formation and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module crfd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  input  wire crfd_pkg::job_t job,
  output logic                job_pop,
  output logic                out_empty,
  input  wire logic           out_pop,
  output logic [7:0]          out_pixel_out
);

  localparam int unsigned PTR_W = $clog2(crfd_pkg::OUT_DEPTH);
  localparam int unsigned CNT_W = $clog2(crfd_pkg::OUT_DEPTH + 1);

  logic [7:0] rdata;
  logic ram_we;
  logic credit_ok;
  logic p1_valid_r;
  logic p1_valid_nxt;
  crfd_pkg::op_t p1_op_r;
  logic [7:0] result;
  logic [7:0] slot_r [crfd_pkg::OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic do_out_pop;

  // A result-producing job goes only when the result queue has room for it.
  assign credit_ok = ({1'b0, cnt_r} + (CNT_W + 1)'(p1_valid_r)) <
                     (CNT_W + 1)'(crfd_pkg::OUT_DEPTH);
  assign job_pop = job_valid && (job.op == crfd_pkg::OP_WRITE || credit_ok);
  assign ram_we = job_pop && job.op == crfd_pkg::OP_WRITE;
  assign p1_valid_nxt = job_pop && job.op != crfd_pkg::OP_WRITE;

  crfd_ram #(
    .WIDTH(8),
    .DEPTH(crfd_pkg::FRAME_DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .addr (job.addr[crfd_pkg::ADDR_W-1:0]),
    .wdata(job.data),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= p1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      p1_op_r <= job.op;
    end
  end

  always_comb begin
    case (p1_op_r)
      crfd_pkg::OP_READ: result = rdata;
      crfd_pkg::OP_BLANK: result = crfd_pkg::BLANK_PIXEL;
      default: result = crfd_pkg::ZERO_PIXEL;
    endcase
  end

  assign out_empty = cnt_r == '0;
  assign out_pixel_out = slot_r[rd_ptr_r];
  assign do_out_pop = out_pop && !out_empty;

  always_comb begin
    wr_ptr_nxt = p1_valid_r ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_out_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt = cnt_r + CNT_W'(p1_valid_r) - CNT_W'(do_out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid_r) begin
      slot_r[wr_ptr_r] <= result;
    end
  end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the camera frame rescaler: frame writes, display reads and every scale mode.
`timescale 1ns / 1ps
module testbench;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PHASE_WORDS = 288;
  localparam logic CMD_W = crfd_pkg::CMD_WRITE;
  localparam logic CMD_R = crfd_pkg::CMD_READ;
  localparam logic [7:0] BLANK = crfd_pkg::BLANK_PIXEL;
  localparam logic [7:0] ZERO = crfd_pkg::ZERO_PIXEL;

  typedef struct packed {
    logic [7:0] pixel;
    logic [5:0] row;
    logic [6:0] col;
  } pixel_expect_t;

  typedef struct packed {
    logic       set_mode;
    logic [1:0] mode;
    logic       cmd;
    logic [15:0] addr;
    logic [7:0] pix;
    logic [5:0] row;
    logic [6:0] col;
    logic       typed;
    logic [7:0] want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic in_command;
  logic [15:0] in_source_address;
  logic [7:0] in_pixel_in;
  logic [5:0] in_display_row;
  logic [6:0] in_display_col;
  logic out_empty;
  logic out_pop;
  logic [7:0] out_pixel_out;
  logic cfg_we;
  logic [1:0] cfg_scale_mode;

  logic typed_flag;
  logic [7:0] typed_pixel;

  logic [7:0] frame_mem [0:crfd_pkg::FRAME_DEPTH-1];
  bit written [0:crfd_pkg::FRAME_DEPTH-1];
  logic [1:0] scale_mode_now = crfd_pkg::MODE_RESET;
  pixel_expect_t pending_pixels [$];
  int err_count = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;

  dir_row_t directed_steps [0:22] = '{
    '{1'b0, 2'd0, CMD_W, 16'd0,     8'hA5, 6'd0,  7'd0,   1'b0, 8'h00},
    '{1'b0, 2'd0, CMD_W, 16'd19038, 8'h5A, 6'd0,  7'd0,   1'b0, 8'h00},
    '{1'b0, 2'd0, CMD_R, 16'd0,     8'h00, 6'd0,  7'd0,   1'b0, 8'h00},
    '{1'b0, 2'd0, CMD_R, 16'd0,     8'h00, 6'd59, 7'd127, 1'b0, 8'h00},
    '{1'b0, 2'd0, CMD_R, 16'd0,     8'h00, 6'd60, 7'd0,   1'b1, BLANK},
    '{1'b0, 2'd0, CMD_R, 16'hFFFF,  8'hFF, 6'd63, 7'd127, 1'b1, BLANK},
    '{1'b0, 2'd0, CMD_W, 16'hFFFF,  8'hFF, 6'd0,  7'd0,   1'b0, 8'h00},
    '{1'b0, 2'd0, CMD_W, 16'd43199, 8'h00, 6'd0,  7'd0,   1'b0, 8'h00},
    '{1'b0, 2'd0, CMD_W, 16'd1,     8'h3C, 6'd63, 7'd127, 1'b0, 8'h00},
    '{1'b0, 2'd0, CMD_R, 16'hFFFF,  8'hFF, 6'd0,  7'd1,   1'b0, 8'h00},
    '{1'b1, crfd_pkg::MODE_SMALL, CMD_W, 16'd0, 8'h00, 6'd0, 7'd0, 1'b0, 8'h00},
    '{1'b0, 2'd0, CMD_R, 16'd0,     8'h00, 6'd0,  7'd0,   1'b0, 8'h00},
    '{1'b0, 2'd0, CMD_W, 16'd4799,  8'h81, 6'd0,  7'd0,   1'b0, 8'h00},
    '{1'b0, 2'd0, CMD_R, 16'd0,     8'h00, 6'd59, 7'd127, 1'b0, 8'h00},
    '{1'b1, crfd_pkg::MODE_LARGE, CMD_W, 16'd0, 8'h00, 6'd0, 7'd0, 1'b0, 8'h00},
    '{1'b0, 2'd0, CMD_R, 16'd0,     8'h00, 6'd0,  7'd0,   1'b0, 8'h00},
    '{1'b0, 2'd0, CMD_W, 16'd42717, 8'h7E, 6'd0,  7'd0,   1'b0, 8'h00},
    '{1'b0, 2'd0, CMD_R, 16'd0,     8'h00, 6'd59, 7'd127, 1'b0, 8'h00},
    '{1'b1, MODE_UNUSED, CMD_W, 16'd0, 8'h00, 6'd0, 7'd0, 1'b0, 8'h00},
    '{1'b0, 2'd0, CMD_R, 16'd0,     8'h00, 6'd0,  7'd0,   1'b1, ZERO},
    '{1'b0, 2'd0, CMD_R, 16'd0,     8'h00, 6'd59, 7'd127, 1'b1, ZERO},
    '{1'b0, 2'd0, CMD_R, 16'd0,     8'h00, 6'd61, 7'd5,   1'b1, BLANK},
    '{1'b1, crfd_pkg::MODE_DIRECT, CMD_W, 16'd0, 8'h00, 6'd0, 7'd0, 1'b0, 8'h00}
  };

  camera_frame_rescale_for_display u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_source_address(in_source_address),
    .in_pixel_in      (in_pixel_in),
    .in_display_row   (in_display_row),
    .in_display_col   (in_display_col),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_out    (out_pixel_out),
    .cfg_we           (cfg_we),
    .cfg_scale_mode   (cfg_scale_mode)
  );

  always #2 clk = ~clk;

  function automatic int source_index(logic [1:0] mode, int r, int c);
    int i;
    int j;
    i = 2 * r;
    j = (c / 4) * 5 + c % 4;
    case (mode)
      crfd_pkg::MODE_SMALL: return (i / 2) * 80 + j / 2;
      crfd_pkg::MODE_DIRECT: return i * 160 + j;
      crfd_pkg::MODE_LARGE: return 3 * (i / 2) * 240 + 3 * (j / 2);
      default: return -1;
    endcase
  endfunction

  function automatic logic [7:0] predict_pixel(logic [1:0] mode, int r, int c);
    int idx;
    if (r >= crfd_pkg::BLANK_ROW) return BLANK;
    idx = source_index(mode, r, c);
    if (idx < 0 || idx >= crfd_pkg::FRAME_DEPTH) return ZERO;
    return frame_mem[idx];
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    err_count++;
    $display("%0t mismatch: %s got %02h want %02h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    pixel_expect_t e;
    if (!rst_n) begin
      scale_mode_now = crfd_pkg::MODE_RESET;
    end else begin
      if (cfg_we) begin
        scale_mode_now = cfg_scale_mode;
      end
      if (!out_empty && out_pop) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("word with nothing pending", out_pixel_out, 8'h00);
        end else begin
          e = pending_pixels.pop_front();
          if (out_pixel_out !== e.pixel) begin
            report_mismatch($sformatf("pixel_out row %0d col %0d", e.row, e.col),
                            out_pixel_out, e.pixel);
          end
        end
      end
      if (in_push && !in_full) begin
        if (in_command == CMD_W) begin
          if (in_source_address < crfd_pkg::FRAME_DEPTH) begin
            frame_mem[in_source_address] = in_pixel_in;
          end
        end else begin
          e.row = in_display_row;
          e.col = in_display_col;
          e.pixel = typed_flag ? typed_pixel :
                    predict_pixel(scale_mode_now, in_display_row, in_display_col);
          pending_pixels.push_back(e);
        end
      end
    end
  end

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_pop = 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      out_pop = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_word(logic cmd, logic [15:0] addr, logic [7:0] pix, logic [5:0] row,
                           logic [6:0] col, logic typed, logic [7:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    if (cmd == CMD_W) written[addr] = 1'b1;
    in_command = cmd;
    in_source_address = addr;
    in_pixel_in = pix;
    in_display_row = row;
    in_display_col = col;
    typed_flag = typed;
    typed_pixel = want;
    in_push = 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic drain();
    in_push = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic set_scale_mode(logic [1:0] m);
    drain();
    repeat (8) @(negedge clk);
    cfg_scale_mode = m;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Reads are preceded by a write of their source entry when it was never written.
  task automatic random_step();
    int pick;
    int r;
    int c;
    int idx;
    logic [15:0] a;
    pick = $urandom_range(99);
    if (pick < 30) begin
      idx = source_index(scale_mode_now, $urandom_range(59), $urandom_range(127));
      a = ($urandom_range(1) || idx < 0) ? 16'($urandom_range(65535)) : 16'(idx);
      send_word(CMD_W, a, 8'($urandom_range(255)), 6'($urandom_range(63)),
                7'($urandom_range(127)), 1'b0, 8'h00);
    end else if (pick < 90) begin
      r = $urandom_range(59);
      c = $urandom_range(127);
      idx = source_index(scale_mode_now, r, c);
      if (idx >= 0 && !written[idx]) begin
        send_word(CMD_W, 16'(idx), 8'($urandom_range(255)), 6'($urandom_range(63)),
                  7'($urandom_range(127)), 1'b0, 8'h00);
      end
      send_word(CMD_R, 16'($urandom_range(65535)), 8'($urandom_range(255)), 6'(r),
                7'(c), 1'b0, 8'h00);
    end else begin
      send_word(CMD_R, 16'($urandom_range(65535)), 8'($urandom_range(255)),
                6'($urandom_range(63, 60)), 7'($urandom_range(127)), 1'b0, 8'h00);
    end
  endtask

  initial begin
    logic [1:0] phase_modes [0:5];
    int start;
    bit hold_done;
    bit pause_done;
    phase_modes = '{crfd_pkg::MODE_SMALL, crfd_pkg::MODE_LARGE, crfd_pkg::MODE_DIRECT,
                    MODE_UNUSED, crfd_pkg::MODE_LARGE, crfd_pkg::MODE_SMALL};
    rst_n = 1'b0;
    in_push = 1'b0;
    in_command = CMD_W;
    in_source_address = '0;
    in_pixel_in = '0;
    in_display_row = '0;
    in_display_col = '0;
    cfg_we = 1'b0;
    cfg_scale_mode = crfd_pkg::MODE_RESET;
    typed_flag = 1'b0;
    typed_pixel = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 83;
    foreach (directed_steps[k]) begin
      if (directed_steps[k].set_mode) begin
        set_scale_mode(directed_steps[k].mode);
      end else begin
        send_word(directed_steps[k].cmd, directed_steps[k].addr, directed_steps[k].pix,
                  directed_steps[k].row, directed_steps[k].col, directed_steps[k].typed,
                  directed_steps[k].want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      set_scale_mode(phase_modes[p]);
      send_idle_pct = (p < 2) ? 12 : (p < 4) ? 83 : 0;
      recv_idle_pct = (p < 2) ? 83 : (p < 4) ? 12 : 0;
      start = words_sent;
      hold_done = 1'b0;
      pause_done = 1'b0;
      while (words_sent - start < PHASE_WORDS) begin
        if ((p == 0 || p == 4) && !hold_done && words_sent - start >= 40) begin
          hold_request = 120;
          hold_done = 1'b1;
        end
        if (!pause_done && words_sent - start >= 150) begin
          drain();
          pause_done = 1'b1;
        end
        random_step();
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
